>>> rtl/msel_pkg.sv
package msel_pkg;

  localparam int MAX_ITEMS    = 64;
  localparam int SAMPLE_W     = 32;
  localparam int MEDIAN_W     = 33;
  localparam int ITEM_COUNT_W = 7;
  localparam int COUNT_W      = $clog2(MAX_ITEMS + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]         count_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/msel_cell.sv
module msel_cell (
  input  logic                clk,
  input  msel_pkg::cell_ctrl_t ctrl,
  input  msel_pkg::sample_t   sample,
  input  msel_pkg::sample_t   prev_value,
  input  logic                prev_gt,
  input  msel_pkg::sample_t   next_value,
  input  logic                occupied,
  input  logic                first_free,
  output msel_pkg::sample_t   value,
  output logic                gt
);
  import msel_pkg::*;

  sample_t value_r;
  sample_t value_nxt;

  assign gt    = occupied && (value_r > sample);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    priority if (ctrl.shift) begin
      value_nxt = next_value;
    end else if (ctrl.load && (gt || first_free)) begin
      value_nxt = prev_gt ? prev_value : sample;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

>>> rtl/msel_chain.sv
module msel_chain (
  input  logic                 clk,
  input  msel_pkg::cell_ctrl_t ctrl,
  input  msel_pkg::sample_t    sample,
  input  msel_pkg::count_t     count,
  output msel_pkg::sample_t    head0,
  output msel_pkg::sample_t    head1
);
  import msel_pkg::*;

  sample_t val [MAX_ITEMS];
  logic    gt  [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    sample_t prev_value;
    logic    prev_gt;
    sample_t next_value;

    if (i == 0) begin : g_first
      assign prev_value = sample;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_value = val[i-1];
      assign prev_gt    = gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign next_value = val[i];
    end else begin : g_link
      assign next_value = val[i+1];
    end

    msel_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sample     (sample),
      .prev_value (prev_value),
      .prev_gt    (prev_gt),
      .next_value (next_value),
      .occupied   (COUNT_W'(i) < count),
      .first_free (COUNT_W'(i) == count),
      .value      (val[i]),
      .gt         (gt[i])
    );
  end

  assign head0 = val[0];

  if (MAX_ITEMS > 1) begin : g_head1
    assign head1 = val[1];
  end else begin : g_head1_single
    assign head1 = val[0];
  end

endmodule

>>> rtl/median_select_top.sv
// median_select_top: median of a set of signed 32-bit samples.
//
// Input stream: one sample per transaction in in_tdata, in_tlast marks the
// final sample of a set. Each sample is inserted into a row of sorted
// cells, so a set streams in at one sample per cycle.
// Samples beyond the capacity of MAX_ITEMS cells are dropped and flagged.
//
// On the last sample the row is shifted toward its head (n-1)/2 times, one
// cell per cycle, bringing the middle values to the first two cells. The
// result is loaded into the output register (out_tvalid) once it is free;
// in_tready stays low from the last sample until that load (n = kept samples).
// Result: twice the median (sum of the two middle values for even n),
// the kept count and the overflow flag.
//
// A result waits in the output register while out_tready is low; loading of
// the next set goes on meanwhile, and a following result waits for the
// register to drain. Reset empties the set and clears out_tvalid.
module median_select_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_value
  input  logic        in_tlast,   // last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [32:0] median_twice, [39:33] item_count
  output logic        out_tuser   // overflow
);
  import msel_pkg::*;

  state_t  state_r, state_nxt;
  count_t  count_r, count_nxt;
  count_t  shift_cnt_r, shift_cnt_nxt;
  logic    dropped_r, dropped_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic [MEDIAN_W-1:0]     median_r, median_nxt;
  logic [ITEM_COUNT_W-1:0] item_count_r, item_count_nxt;
  logic    overflow_r, overflow_nxt;

  cell_ctrl_t ctrl;
  logic       take_result;
  logic       in_acc;
  logic       full;
  sample_t    head0, head1;
  count_t     count_inc;

  msel_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (in_tdata),
    .count  (count_r),
    .head0  (head0),
    .head1  (head1)
  );

  assign in_acc    = in_tvalid && in_tready;
  assign full      = (count_r == COUNT_W'(MAX_ITEMS));
  assign count_inc = full ? count_r : count_r + COUNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (shift_cnt_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    ctrl        = '0;
    take_result = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        ctrl.load = in_tvalid && !full;
      end
      ST_SHIFT: begin
        ctrl.shift = (shift_cnt_r != '0);
      end
      ST_DONE: begin
        take_result = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    dropped_nxt    = dropped_r;
    shift_cnt_nxt  = shift_cnt_r;
    out_valid_nxt  = out_valid_r;
    median_nxt     = median_r;
    item_count_nxt = item_count_r;
    overflow_nxt   = overflow_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    if (in_acc) begin
      count_nxt   = count_inc;
      dropped_nxt = dropped_r || full;
      if (in_tlast) shift_cnt_nxt = (count_inc - COUNT_W'(1)) >> 1;
    end

    if (ctrl.shift) shift_cnt_nxt = shift_cnt_r - COUNT_W'(1);

    if (take_result) begin
      out_valid_nxt  = 1'b1;
      median_nxt     = count_r[0]
                     ? {head0, 1'b0}
                     : {head0[SAMPLE_W-1], head0} + {head1[SAMPLE_W-1], head1};
      item_count_nxt = ITEM_COUNT_W'(count_r);
      overflow_nxt   = dropped_r;
      count_nxt      = '0;
      dropped_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      shift_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      shift_cnt_r <= shift_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    median_r     <= median_nxt;
    item_count_r <= item_count_nxt;
    overflow_r   <= overflow_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {item_count_r, median_r};
  assign out_tuser  = overflow_r;

  a_last_starts_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r == ST_SHIFT))
    else $error("last transaction did not start the shift phase");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_ITEMS))
    else $error("kept count exceeds capacity");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    dropped_r |-> full)
    else $error("overflow flagged while store not full");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (shift_cnt_r < count_r))
    else $error("shift count beyond kept samples");

  a_result_clears_set: assert property (@(posedge clk) disable iff (!rst_n)
    take_result |=> (count_r == '0 && !dropped_r && out_tvalid))
    else $error("result load did not empty the set");

endmodule

>>> tb/tb_median_select_top.sv
`timescale 1ns / 100ps

module tb_median_select_top;
  import msel_pkg::*;

  localparam int TOTAL_ITEMS = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam sample_t SAMPLE_MAX = 32'sh7fffffff;
  localparam sample_t SAMPLE_MIN = 32'sh80000000;

  typedef struct {
    sample_t sample;
    logic    last;
    logic    drain_first;
  } sample_item_t;

  typedef struct {
    logic signed [MEDIAN_W-1:0] median_twice;
    logic [ITEM_COUNT_W-1:0]    item_count;
    logic                       overflow;
  } median_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] sample_value
  logic        in_tlast = 1'b0; // last_item
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [32:0] median_twice, [39:33] item_count
  logic        out_tuser;       // overflow

  sample_item_t   pending_q[$];
  median_result_t median_q[$];

  sample_t sorted_row[MAX_ITEMS];
  int      row_len = 0;
  logic    row_dropped = 1'b0;

  int queued_items = 0;
  int accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;

  median_select_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int send_idle_pct();
    if (accepted < queued_items / 3) return 8;
    if (accepted < 2 * queued_items / 3) return 86;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted < queued_items / 3) return 86;
    if (accepted < 2 * queued_items / 3) return 8;
    return 0;
  endfunction

  function automatic void insert_and_close(input sample_t v, input logic last);
    int pos;
    logic signed [MEDIAN_W-1:0] lo_mid;
    logic signed [MEDIAN_W-1:0] hi_mid;
    median_result_t res;
    if (row_len < MAX_ITEMS) begin
      pos = row_len;
      while (pos > 0 && sorted_row[pos-1] > v) begin
        sorted_row[pos] = sorted_row[pos-1];
        pos--;
      end
      sorted_row[pos] = v;
      row_len++;
    end else begin
      row_dropped = 1'b1;
    end
    if (last) begin
      lo_mid = sorted_row[(row_len - 1) / 2];
      hi_mid = sorted_row[row_len / 2];
      res.median_twice = lo_mid + hi_mid;
      res.item_count = row_len[ITEM_COUNT_W-1:0];
      res.overflow = row_dropped;
      median_q.push_back(res);
      row_len = 0;
      row_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t result %0d: %s got 0x%0h expected 0x%0h",
               $time, results_seen, field, got, want);
  endtask

  function automatic void queue_sample(input sample_t v, input logic last,
                                       input logic drain_first = 1'b0);
    sample_item_t it;
    it.sample = v;
    it.last = last;
    it.drain_first = drain_first;
    pending_q.push_back(it);
  endfunction

  function automatic sample_t pick_sample(input int mode);
    int s;
    case (mode)
      0: return sample_t'($urandom);
      1: begin
        s = int'($urandom_range(16)) - 8;
        return sample_t'(s);
      end
      default: begin
        case ($urandom_range(4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return sample_t'(0);
          3: return sample_t'(-1);
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic void queue_set(input int len, input int mode, input logic drain_first);
    for (int i = 0; i < len; i++)
      queue_sample(pick_sample(mode), i == len - 1, drain_first && i == 0);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        insert_and_close(sample_t'(in_tdata), in_tlast);
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct() &&
            !(pending_q[0].drain_first && median_q.size() != 0)) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_q[0].sample;
          in_tlast <= pending_q[0].last;
          void'(pending_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : result_monitor
    median_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (median_q.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(out_tdata), 64'(0));
        end else begin
          want = median_q.pop_front();
          if (out_tdata[32:0] !== want.median_twice)
            report_mismatch("median_twice", 64'(out_tdata[32:0]), 64'(want.median_twice));
          if (out_tdata[39:33] !== want.item_count)
            report_mismatch("item_count", 64'(out_tdata[39:33]), 64'(want.item_count));
          if (out_tuser !== want.overflow)
            report_mismatch("overflow", 64'(out_tuser), 64'(want.overflow));
        end
        results_seen++;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int len;
    int mode;

    queue_sample(SAMPLE_MAX, 1'b1);
    queue_sample(SAMPLE_MIN, 1'b1);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b1);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1);
    queue_sample(sample_t'(0), 1'b0);
    queue_sample(sample_t'(-1), 1'b0);
    queue_sample(sample_t'(1), 1'b1);
    for (int i = 0; i < 4; i++)
      queue_sample(sample_t'(5), i == 3);
    queue_sample(sample_t'(3), 1'b0);
    queue_sample(sample_t'(-7), 1'b0);
    queue_sample(sample_t'(100), 1'b0);
    queue_sample(sample_t'(-7), 1'b0);
    queue_sample(sample_t'(2), 1'b1);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(sample_t'(0), 1'b0);
    queue_sample(SAMPLE_MIN + 1, 1'b0);
    queue_sample(SAMPLE_MAX - 1, 1'b0);
    queue_sample(sample_t'(-1), 1'b1);

    // full row, full row with the closing sample dropped, then random sets
    queue_set(MAX_ITEMS, 0, 1'b1);
    queue_set(MAX_ITEMS + 1, 0, 1'b0);
    while (pending_q.size() < TOTAL_ITEMS) begin
      if ($urandom_range(99) < 4) begin
        case ($urandom_range(3))
          0: len = MAX_ITEMS - 1;
          1: len = MAX_ITEMS;
          2: len = MAX_ITEMS + 1;
          default: len = $urandom_range(MAX_ITEMS + 16, MAX_ITEMS + 2);
        endcase
      end else begin
        len = $urandom_range(10, 1);
      end
      mode = $urandom_range(2);
      queue_set(len, mode, $urandom_range(99) < 3);
    end
    queued_items = pending_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_tvalid || median_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && median_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/msel_pkg.sv
rtl/msel_cell.sv
rtl/msel_chain.sv
rtl/median_select_top.sv
tb/tb_median_select_top.sv
